// ===== rtl/vrc4m_pkg.sv =====
// Shared types, codes and constants of the VRC4-style bank mapper.
package vrc4m_pkg;

  localparam logic [2:0] REQ_CPU_READ  = 3'd0;
  localparam logic [2:0] REQ_CPU_WRITE = 3'd1;
  localparam logic [2:0] REQ_PPU_READ  = 3'd2;
  localparam logic [2:0] REQ_PPU_WRITE = 3'd3;
  localparam logic [2:0] REQ_TICK      = 3'd4;
  localparam logic [2:0] REQ_IRQ_CLEAR = 3'd5;

  localparam logic [1:0] CFG_PRG_BANKS  = 2'd0;
  localparam logic [1:0] CFG_WIRING     = 2'd1;
  localparam logic [1:0] CFG_CHR_IS_RAM = 2'd2;

  localparam logic [3:0] BLK_PRG0    = 4'h8;
  localparam logic [3:0] BLK_MODE    = 4'h9;
  localparam logic [3:0] BLK_PRG1    = 4'hA;
  localparam logic [3:0] BLK_CHR_LO  = 4'hB;
  localparam logic [3:0] BLK_CHR_HI  = 4'hE;
  localparam logic [3:0] BLK_IRQ     = 4'hF;

  localparam logic [1:0] IRQ_LATCH_RELOAD_LO = 2'd0;
  localparam logic [1:0] IRQ_LATCH_RELOAD_HI = 2'd1;
  localparam logic [1:0] IRQ_LATCH_CONTROL   = 2'd2;
  localparam logic [1:0] IRQ_LATCH_ACK       = 2'd3;

  localparam logic [9:0] PRESCALE_PERIOD = 10'd341;
  localparam logic [9:0] PRESCALE_RELOAD = PRESCALE_PERIOD - 10'd1;

  localparam logic [7:0] PRG_BANKS_RESET = 8'd16;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [20:0] xlat_addr;
    logic        irq_active;
    logic [1:0]  mirror_mode;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] index;
    logic [7:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0]       prg_banks_16k;
    logic             wiring_variant;
    logic             chr_is_ram;
    logic [7:0]       prg_select0;
    logic [7:0]       prg_select1;
    logic             prg_swap;
    logic [1:0]       mirroring;
    logic [7:0][7:0]  chr_select;
  } map_state_t;

  typedef struct packed {
    logic       irq_line;
    logic [1:0] mirroring;
  } status_t;

endpackage

// ===== rtl/vrc4m_req_if.sv =====
// Request channel: access type, bus address and write byte.
interface vrc4m_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] bus_addr;
  logic [7:0]  write_data;

  modport source (output valid, req_type, bus_addr, write_data, input ready);
  modport sink (input valid, req_type, bus_addr, write_data, output ready);
endinterface

// ===== rtl/vrc4m_res_if.sv =====
// Result channel: hit flag, translated address, IRQ level and mirroring.
interface vrc4m_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [20:0] xlat_addr;
  logic        irq_active;
  logic [1:0]  mirror_mode;

  modport source (output valid, hit, xlat_addr, irq_active, mirror_mode, input ready);
  modport sink (input valid, hit, xlat_addr, irq_active, mirror_mode, output ready);
endinterface

// ===== rtl/vrc4m_cfg_if.sv =====
// Configuration write channel: register index and data.
interface vrc4m_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/vrc4m_regs.sv =====
// Mapper registers, CPU write decode and IRQ prescaler/counter.
module vrc4m_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  vrc4m_pkg::cfg_wr_t   cfg_wr,
  input  logic                 fire,
  input  vrc4m_pkg::req_t      item,
  output vrc4m_pkg::map_state_t state,
  output vrc4m_pkg::status_t   status_next
);

  vrc4m_pkg::map_state_t state_next;
  logic [7:0] irq_reload_value;
  logic [7:0] irq_reload_value_next;
  logic [7:0] irq_count;
  logic [7:0] irq_count_next;
  logic [9:0] irq_prescale;
  logic [9:0] irq_prescale_next;
  logic       irq_enabled;
  logic       irq_enabled_next;
  logic       irq_enable_after_ack;
  logic       irq_enable_after_ack_next;
  logic       irq_line;
  logic       irq_line_next;

  logic [7:0] bank_mask;
  logic       a0;
  logic       a1;
  logic [1:0] latch;
  logic [3:0] blk;
  logic [2:0] chr_idx;
  logic [1:0] chr_pair;

  always_comb begin
    bank_mask = {state.prg_banks_16k[6:0], 1'b0} - 8'd1;
    a0 = state.wiring_variant ? item.bus_addr[6] : item.bus_addr[1];
    a1 = state.wiring_variant ? item.bus_addr[7] : item.bus_addr[2];
    latch = {a1, a0};
    blk = item.bus_addr[15:12];
    chr_pair = blk[1:0] + 2'd1;
    chr_idx = {chr_pair, a1};

    state_next = state;
    irq_reload_value_next = irq_reload_value;
    irq_count_next = irq_count;
    irq_prescale_next = irq_prescale;
    irq_enabled_next = irq_enabled;
    irq_enable_after_ack_next = irq_enable_after_ack;
    irq_line_next = irq_line;

    if (fire) begin
      case (item.req_type)
        vrc4m_pkg::REQ_CPU_WRITE: begin
          if (item.bus_addr[15]) begin
            if (blk inside {[vrc4m_pkg::BLK_CHR_LO : vrc4m_pkg::BLK_CHR_HI]}) begin
              if (a0) begin
                state_next.chr_select[chr_idx][7:4] = item.write_data[3:0];
              end else begin
                state_next.chr_select[chr_idx][3:0] = item.write_data[3:0];
              end
            end else begin
              case (blk)
                vrc4m_pkg::BLK_PRG0: begin
                  if (!a0) begin
                    state_next.prg_select0 = item.write_data & bank_mask;
                  end
                end
                vrc4m_pkg::BLK_PRG1: begin
                  if (!a0) begin
                    state_next.prg_select1 = item.write_data & bank_mask;
                  end
                end
                vrc4m_pkg::BLK_MODE: begin
                  if (!a0) begin
                    state_next.prg_swap = item.write_data[1];
                  end else begin
                    state_next.mirroring = item.write_data[1:0];
                  end
                end
                vrc4m_pkg::BLK_IRQ: begin
                  case (latch)
                    vrc4m_pkg::IRQ_LATCH_RELOAD_LO: begin
                      irq_reload_value_next[3:0] = item.write_data[3:0];
                    end
                    vrc4m_pkg::IRQ_LATCH_RELOAD_HI: begin
                      irq_reload_value_next[7:4] = item.write_data[3:0];
                    end
                    vrc4m_pkg::IRQ_LATCH_CONTROL: begin
                      irq_enable_after_ack_next = item.write_data[0];
                      irq_enabled_next = item.write_data[1];
                      if (item.write_data[1]) begin
                        irq_count_next = irq_reload_value;
                      end
                      irq_prescale_next = vrc4m_pkg::PRESCALE_PERIOD;
                      irq_line_next = 1'b0;
                    end
                    default: begin
                      irq_line_next = 1'b0;
                      irq_enabled_next = irq_enable_after_ack;
                    end
                  endcase
                end
                default: begin
                end
              endcase
            end
          end
        end
        vrc4m_pkg::REQ_TICK: begin
          if (irq_enabled) begin
            if (irq_prescale == 10'd0) begin
              irq_prescale_next = vrc4m_pkg::PRESCALE_RELOAD;
              if (irq_count == 8'd0) begin
                irq_count_next = irq_reload_value;
                irq_line_next = 1'b1;
              end else begin
                irq_count_next = irq_count - 8'd1;
              end
            end else begin
              irq_prescale_next = irq_prescale - 10'd1;
            end
          end
        end
        vrc4m_pkg::REQ_IRQ_CLEAR: begin
          irq_line_next = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        vrc4m_pkg::CFG_PRG_BANKS: state_next.prg_banks_16k = cfg_wr.data;
        vrc4m_pkg::CFG_WIRING: state_next.wiring_variant = cfg_wr.data[0];
        vrc4m_pkg::CFG_CHR_IS_RAM: state_next.chr_is_ram = cfg_wr.data[0];
        default: begin
        end
      endcase
    end

    status_next.irq_line = irq_line_next;
    status_next.mirroring = state_next.mirroring;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.prg_banks_16k <= vrc4m_pkg::PRG_BANKS_RESET;
      state.wiring_variant <= 1'b0;
      state.chr_is_ram <= 1'b0;
      state.prg_select0 <= 8'd0;
      state.prg_select1 <= 8'd1;
      state.prg_swap <= 1'b0;
      state.mirroring <= 2'd0;
      state.chr_select <= '0;
      irq_reload_value <= 8'd0;
      irq_count <= 8'd0;
      irq_prescale <= vrc4m_pkg::PRESCALE_PERIOD;
      irq_enabled <= 1'b0;
      irq_enable_after_ack <= 1'b0;
      irq_line <= 1'b0;
    end else begin
      state <= state_next;
      irq_reload_value <= irq_reload_value_next;
      irq_count <= irq_count_next;
      irq_prescale <= irq_prescale_next;
      irq_enabled <= irq_enabled_next;
      irq_enable_after_ack <= irq_enable_after_ack_next;
      irq_line <= irq_line_next;
    end
  end

endmodule

// ===== rtl/vrc4m_map.sv =====
// PRG and CHR address translation with hit flag.
module vrc4m_map (
  input  vrc4m_pkg::req_t       item,
  input  vrc4m_pkg::map_state_t state,
  output logic                  hit,
  output logic [20:0]           xlat_addr
);

  logic [7:0] bank_count8;
  logic [7:0] fixed_bank;
  logic [7:0] last_bank;
  logic [7:0] prg_bank;

  always_comb begin
    bank_count8 = {state.prg_banks_16k[6:0], 1'b0};
    fixed_bank = bank_count8 - 8'd2;
    last_bank = bank_count8 - 8'd1;
    case (item.bus_addr[14:13])
      2'd0: prg_bank = state.prg_swap ? fixed_bank : state.prg_select0;
      2'd1: prg_bank = state.prg_select1;
      2'd2: prg_bank = state.prg_swap ? state.prg_select0 : fixed_bank;
      default: prg_bank = last_bank;
    endcase

    hit = 1'b0;
    xlat_addr = 21'd0;
    case (item.req_type)
      vrc4m_pkg::REQ_CPU_READ: begin
        if (item.bus_addr[15]) begin
          hit = 1'b1;
          xlat_addr = {prg_bank, item.bus_addr[12:0]};
        end
      end
      vrc4m_pkg::REQ_PPU_READ: begin
        if (item.bus_addr[15:13] == 3'd0) begin
          hit = 1'b1;
          xlat_addr = {3'd0, state.chr_select[item.bus_addr[12:10]], item.bus_addr[9:0]};
        end
      end
      vrc4m_pkg::REQ_PPU_WRITE: begin
        if (item.bus_addr[15:13] == 3'd0 && state.chr_is_ram) begin
          hit = 1'b1;
          xlat_addr = {5'd0, item.bus_addr};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/vrc4_bank_mapper_irq.sv =====
// Top level of the VRC4-style bank mapper with scanline IRQ timer.
//
// Channels: req carries one bus access, tick or IRQ clear per item; res returns
// exactly one result item per request item, in order: hit, translated address,
// IRQ line level and mirroring after that item. cfg writes the PRG bank count,
// the latch wiring variant and the CHR RAM flag; it is always ready. The user
// must write it only while no request is in flight; the block does not enforce this.
// Flow: an accepted request is held in the input register; it is translated and
// its state update applied as it moves into the result register, which res
// offers.
// Throughput: one item per cycle while res is ready, set by the single pass
// through write decode and address map between the input and result registers.
// Stall: while res is not taken the result register holds; one more item waits
// in the input register and req.ready drops until the result moves.
// Reset: rst clears both stages, sets PRG select 1 to bank 1, the prescaler to
// its full period, all other bank and IRQ state to zero and the bank count to 16.
module vrc4_bank_mapper_irq (
  input  logic               clk,
  input  logic               rst,
  vrc4m_cfg_if.sink          cfg,
  vrc4m_req_if.sink          req,
  vrc4m_res_if.source        res
);

  logic                  in_valid;
  vrc4m_pkg::req_t       in_item;
  logic                  out_valid;
  vrc4m_pkg::res_t       out_res;
  logic                  advance;
  vrc4m_pkg::cfg_wr_t    cfg_wr;
  vrc4m_pkg::map_state_t state;
  vrc4m_pkg::status_t    status_next;
  logic                  map_hit;
  logic [20:0]           map_addr;

  assign advance = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;
  assign cfg_wr.valid = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data = cfg.data;

  vrc4m_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .fire        (advance),
    .item        (in_item),
    .state       (state),
    .status_next (status_next)
  );

  vrc4m_map u_map (
    .item        (in_item),
    .state       (state),
    .hit         (map_hit),
    .xlat_addr   (map_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.req_type <= req.req_type;
      in_item.bus_addr <= req.bus_addr;
      in_item.write_data <= req.write_data;
    end
    if (advance) begin
      out_res.hit <= map_hit;
      out_res.xlat_addr <= map_addr;
      out_res.irq_active <= status_next.irq_line;
      out_res.mirror_mode <= status_next.mirroring;
    end
  end

  assign res.valid = out_valid;
  assign res.hit = out_res.hit;
  assign res.xlat_addr = out_res.xlat_addr;
  assign res.irq_active = out_res.irq_active;
  assign res.mirror_mode = out_res.mirror_mode;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !res.ready |-> !req.ready)
    else $error("input taken while both stages are full");

  a_miss_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.hit |-> out_res.xlat_addr == 21'd0)
    else $error("missed access carries an address");

  a_irq_rises_on_tick: assert property (@(posedge clk) disable iff (rst || $past(rst))
    $rose(status_next.irq_line) |-> advance && in_item.req_type == vrc4m_pkg::REQ_TICK)
    else $error("IRQ line raised by a non-tick item");

  a_mirror_only_on_write: assert property (@(posedge clk) disable iff (rst || $past(rst))
    !$stable(state.mirroring) |-> $past(advance && in_item.req_type == vrc4m_pkg::REQ_CPU_WRITE))
    else $error("mirroring changed without a CPU write");
`endif

endmodule

// ===== verif/tb_vrc4_bank_mapper_irq.sv =====
// Testbench for the VRC4-style bank mapper: random and directed bus traffic checked against a predictor.
`timescale 1ns / 100ps

module tb_vrc4_bank_mapper_irq;

  localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

  class bank_irq_scoreboard;
    logic [7:0] prg_banks;
    logic       wiring;
    logic       chr_ram;
    logic [7:0] prg_sel [2];
    logic       prg_swap;
    logic [1:0] mirroring;
    logic [7:0] chr_sel [8];
    logic [7:0] reload_val;
    logic [7:0] irq_count;
    logic [9:0] prescale;
    logic       irq_en;
    logic       irq_en_ack;
    logic       irq_line;
    vrc4m_pkg::res_t pending_res [$];
    int         errors;

    function new();
      prg_banks  = vrc4m_pkg::PRG_BANKS_RESET;
      wiring     = 1'b0;
      chr_ram    = 1'b0;
      prg_sel[0] = 8'd0;
      prg_sel[1] = 8'd1;
      prg_swap   = 1'b0;
      mirroring  = 2'd0;
      foreach (chr_sel[i]) chr_sel[i] = 8'd0;
      reload_val = 8'd0;
      irq_count  = 8'd0;
      prescale   = vrc4m_pkg::PRESCALE_PERIOD;
      irq_en     = 1'b0;
      irq_en_ack = 1'b0;
      irq_line   = 1'b0;
      errors     = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] val);
      case (idx)
        vrc4m_pkg::CFG_PRG_BANKS:  prg_banks = val;
        vrc4m_pkg::CFG_WIRING:     wiring = val[0];
        vrc4m_pkg::CFG_CHR_IS_RAM: chr_ram = val[0];
        default: ;
      endcase
    endfunction

    function void decode_write(logic [15:0] addr, logic [7:0] data);
      logic       a0;
      logic       a1;
      logic [3:0] blk;
      logic [7:0] mask;
      logic [2:0] k;
      if (!addr[15]) return;
      a0   = wiring ? addr[6] : addr[1];
      a1   = wiring ? addr[7] : addr[2];
      blk  = addr[15:12];
      mask = {prg_banks[6:0], 1'b0} - 8'd1;
      case (blk)
        vrc4m_pkg::BLK_PRG0: begin
          if (!a0) prg_sel[0] = data & mask;
        end
        vrc4m_pkg::BLK_PRG1: begin
          if (!a0) prg_sel[1] = data & mask;
        end
        vrc4m_pkg::BLK_MODE: begin
          if (!a0) prg_swap = data[1];
          else mirroring = data[1:0];
        end
        vrc4m_pkg::BLK_IRQ: begin
          case ({a1, a0})
            vrc4m_pkg::IRQ_LATCH_RELOAD_LO: reload_val[3:0] = data[3:0];
            vrc4m_pkg::IRQ_LATCH_RELOAD_HI: reload_val[7:4] = data[3:0];
            vrc4m_pkg::IRQ_LATCH_CONTROL: begin
              irq_en_ack = data[0];
              irq_en     = data[1];
              if (irq_en) irq_count = reload_val;
              prescale = vrc4m_pkg::PRESCALE_PERIOD;
              irq_line = 1'b0;
            end
            default: begin
              irq_line = 1'b0;
              irq_en   = irq_en_ack;
            end
          endcase
        end
        default: begin
          if (blk >= vrc4m_pkg::BLK_CHR_LO && blk <= vrc4m_pkg::BLK_CHR_HI) begin
            k = {2'(blk - vrc4m_pkg::BLK_CHR_LO), a1};
            if (a0) chr_sel[k][7:4] = data[3:0];
            else chr_sel[k][3:0] = data[3:0];
          end
        end
      endcase
    endfunction

    function void step_timer();
      if (!irq_en) return;
      if (prescale == 10'd0) begin
        prescale = vrc4m_pkg::PRESCALE_RELOAD;
        if (irq_count == 8'd0) begin
          irq_count = reload_val;
          irq_line  = 1'b1;
        end else begin
          irq_count = irq_count - 8'd1;
        end
      end else begin
        prescale = prescale - 10'd1;
      end
    endfunction

    function void note_request(vrc4m_pkg::req_t r);
      vrc4m_pkg::res_t e;
      logic [7:0] cnt8;
      logic [7:0] bank;
      e    = '0;
      cnt8 = {prg_banks[6:0], 1'b0};
      case (r.req_type)
        vrc4m_pkg::REQ_CPU_READ: begin
          if (r.bus_addr[15]) begin
            case (r.bus_addr[14:13])
              2'd0:    bank = prg_swap ? cnt8 - 8'd2 : prg_sel[0];
              2'd1:    bank = prg_sel[1];
              2'd2:    bank = prg_swap ? prg_sel[0] : cnt8 - 8'd2;
              default: bank = cnt8 - 8'd1;
            endcase
            e.hit       = 1'b1;
            e.xlat_addr = {bank, r.bus_addr[12:0]};
          end
        end
        vrc4m_pkg::REQ_CPU_WRITE: decode_write(r.bus_addr, r.write_data);
        vrc4m_pkg::REQ_PPU_READ: begin
          if (r.bus_addr < 16'h2000) begin
            e.hit       = 1'b1;
            e.xlat_addr = {3'd0, chr_sel[r.bus_addr[12:10]], r.bus_addr[9:0]};
          end
        end
        vrc4m_pkg::REQ_PPU_WRITE: begin
          if (r.bus_addr < 16'h2000 && chr_ram) begin
            e.hit       = 1'b1;
            e.xlat_addr = {5'd0, r.bus_addr};
          end
        end
        vrc4m_pkg::REQ_TICK:      step_timer();
        vrc4m_pkg::REQ_IRQ_CLEAR: irq_line = 1'b0;
        default: ;
      endcase
      e.irq_active  = irq_line;
      e.mirror_mode = mirroring;
      pending_res.push_back(e);
    endfunction

    function void check_result(vrc4m_pkg::res_t got);
      vrc4m_pkg::res_t e;
      if (pending_res.size() == 0) begin
        $error("result item with no request outstanding");
        errors++;
        return;
      end
      e = pending_res.pop_front();
      if (got.hit !== e.hit) begin
        $error("hit: expected %0d, actual %0d", e.hit, got.hit);
        errors++;
      end
      if (got.xlat_addr !== e.xlat_addr) begin
        $error("xlat_addr: expected 0x%06h, actual 0x%06h", e.xlat_addr, got.xlat_addr);
        errors++;
      end
      if (got.irq_active !== e.irq_active) begin
        $error("irq_active: expected %0d, actual %0d", e.irq_active, got.irq_active);
        errors++;
      end
      if (got.mirror_mode !== e.mirror_mode) begin
        $error("mirror_mode: expected %0d, actual %0d", e.mirror_mode, got.mirror_mode);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  vrc4m_cfg_if cfg_bus ();
  vrc4m_req_if req_bus ();
  vrc4m_res_if res_bus ();

  vrc4_bank_mapper_irq u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .res (res_bus)
  );

  bank_irq_scoreboard sb;
  bit send_eager;
  int sent_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] reg_addr(logic [3:0] blk, logic [1:0] latch);
    logic [15:0] a;
    a = {blk, 12'($urandom)};
    if (sb.wiring) {a[7], a[6]} = latch;
    else {a[2], a[1]} = latch;
    return a;
  endfunction

  task automatic send_req(input logic [2:0] kind, input logic [15:0] addr,
                          input logic [7:0] data);
    int   gap;
    vrc4m_pkg::req_t r;
    gap = send_eager ? 0 : pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= kind;
    req_bus.bus_addr   <= addr;
    req_bus.write_data <= data;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    r.req_type   = kind;
    r.bus_addr   = addr;
    r.write_data = data;
    sb.note_request(r);
    sent_count++;
  endtask

  task automatic send_write(input logic [3:0] blk, input logic [1:0] latch,
                            input logic [7:0] data);
    send_req(vrc4m_pkg::REQ_CPU_WRITE, reg_addr(blk, latch), data);
  endtask

  task automatic apply_config(input logic [7:0] banks, input logic w, input logic ram);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx = '{vrc4m_pkg::CFG_PRG_BANKS, vrc4m_pkg::CFG_WIRING, vrc4m_pkg::CFG_CHR_IS_RAM};
    val = '{banks, {7'd0, w}, {7'd0, ram}};
    cfg_bus.valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_bus.index <= idx[i];
      cfg_bus.data  <= val[i];
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
      sb.set_register(idx[i], val[i]);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (sb.pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_directed();
    send_req(vrc4m_pkg::REQ_CPU_READ, 16'h0000, 8'h00);
    send_req(vrc4m_pkg::REQ_CPU_READ, 16'hFFFF, 8'h00);
    send_req(vrc4m_pkg::REQ_CPU_READ, 16'h8000, 8'h00);
    send_write(vrc4m_pkg::BLK_PRG0, 2'b00, 8'hFF);
    send_req(vrc4m_pkg::REQ_CPU_WRITE, 16'h7FFF, 8'hFF);
    send_write(vrc4m_pkg::BLK_PRG0, 2'b01, 8'h05);
    send_write(vrc4m_pkg::BLK_MODE, 2'b00, 8'h02);
    send_write(vrc4m_pkg::BLK_MODE, 2'b01, 8'h03);
    send_req(vrc4m_pkg::REQ_CPU_READ, 16'h8000, 8'h00);
    send_req(vrc4m_pkg::REQ_CPU_READ, 16'hC123, 8'h00);
    send_write(vrc4m_pkg::BLK_CHR_LO, 2'b00, 8'h0F);
    send_write(vrc4m_pkg::BLK_CHR_LO, 2'b01, 8'hFF);
    send_req(vrc4m_pkg::REQ_PPU_READ, 16'h0000, 8'h00);
    send_req(vrc4m_pkg::REQ_PPU_READ, 16'h1FFF, 8'h00);
    send_req(vrc4m_pkg::REQ_PPU_READ, 16'h2000, 8'h00);
    send_req(vrc4m_pkg::REQ_PPU_WRITE, 16'h0100, 8'hA5);
    send_write(vrc4m_pkg::BLK_IRQ, vrc4m_pkg::IRQ_LATCH_CONTROL, 8'h03);
    send_req(vrc4m_pkg::REQ_TICK, 16'h0000, 8'h00);
    send_req(vrc4m_pkg::REQ_IRQ_CLEAR, 16'h0000, 8'h00);
    send_write(vrc4m_pkg::BLK_IRQ, vrc4m_pkg::IRQ_LATCH_ACK, 8'h00);
    send_req(REQ_UNUSED_6, 16'h8000, 8'h00);
    send_req(REQ_UNUSED_7, 16'hFFFF, 8'hFF);
    wait_idle();
    apply_config(vrc4m_pkg::PRG_BANKS_RESET, 1'b0, 1'b1);
    send_req(vrc4m_pkg::REQ_PPU_WRITE, 16'h1FFF, 8'h5A);
    send_req(vrc4m_pkg::REQ_PPU_WRITE, 16'hFFFF, 8'h5A);
  endtask

  task automatic run_long_timer();
    int n;
    send_write(vrc4m_pkg::BLK_IRQ, vrc4m_pkg::IRQ_LATCH_RELOAD_LO,
               {4'($urandom), 3'd0, 1'($urandom)});
    send_write(vrc4m_pkg::BLK_IRQ, vrc4m_pkg::IRQ_LATCH_RELOAD_HI, {4'($urandom), 4'd0});
    send_write(vrc4m_pkg::BLK_IRQ, vrc4m_pkg::IRQ_LATCH_CONTROL,
               {6'($urandom), 1'b1, 1'($urandom)});
    n = $urandom_range(342, 400);
    repeat (n) send_req(vrc4m_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
    send_req(vrc4m_pkg::REQ_CPU_READ, 16'($urandom), 8'($urandom));
    if ($urandom_range(0, 1) == 0)
      send_write(vrc4m_pkg::BLK_IRQ, vrc4m_pkg::IRQ_LATCH_ACK, 8'($urandom));
    else
      send_req(vrc4m_pkg::REQ_IRQ_CLEAR, 16'($urandom), 8'($urandom));
  endtask

  task automatic run_random(input int target);
    int         r;
    int         n;
    int         stop;
    logic [3:0] blk;
    stop = sent_count + target;
    while (sent_count < stop) begin
      if ($urandom_range(0, 4) == 0) send_eager = !send_eager;
      r = $urandom_range(0, 99);
      if (r < 22) begin
        send_write(vrc4m_pkg::BLK_PRG0, {1'($urandom), 1'b0}, 8'($urandom));
        send_write(vrc4m_pkg::BLK_PRG1, {1'($urandom), 1'b0}, 8'($urandom));
        send_write(vrc4m_pkg::BLK_MODE, {1'($urandom), 1'b0}, 8'($urandom));
        n = $urandom_range(2, 6);
        repeat (n) send_req(vrc4m_pkg::REQ_CPU_READ, {1'b1, 15'($urandom)}, 8'($urandom));
      end else if (r < 40) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          blk = 4'($urandom_range(vrc4m_pkg::BLK_CHR_LO, vrc4m_pkg::BLK_CHR_HI));
          send_write(blk, 2'($urandom), 8'($urandom));
        end
        n = $urandom_range(2, 6);
        repeat (n) send_req(vrc4m_pkg::REQ_PPU_READ, {3'd0, 13'($urandom)}, 8'($urandom));
      end else if (r < 50) begin
        send_write(vrc4m_pkg::BLK_MODE, {1'($urandom), 1'b1}, 8'($urandom));
        n = $urandom_range(2, 5);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0)
            send_req(vrc4m_pkg::REQ_PPU_WRITE, {3'd0, 13'($urandom)}, 8'($urandom));
          else
            send_req(vrc4m_pkg::REQ_PPU_WRITE, 16'($urandom), 8'($urandom));
        end
        send_req(vrc4m_pkg::REQ_PPU_READ, 16'($urandom), 8'($urandom));
      end else if (r < 62) begin
        send_write(vrc4m_pkg::BLK_IRQ, vrc4m_pkg::IRQ_LATCH_RELOAD_LO, 8'($urandom));
        send_write(vrc4m_pkg::BLK_IRQ, vrc4m_pkg::IRQ_LATCH_RELOAD_HI, 8'($urandom));
        send_write(vrc4m_pkg::BLK_IRQ, vrc4m_pkg::IRQ_LATCH_CONTROL, 8'($urandom));
        n = $urandom_range(1, 25);
        repeat (n) send_req(vrc4m_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
        if ($urandom_range(0, 1) == 0)
          send_write(vrc4m_pkg::BLK_IRQ, vrc4m_pkg::IRQ_LATCH_ACK, 8'($urandom));
        else
          send_req(vrc4m_pkg::REQ_IRQ_CLEAR, 16'($urandom), 8'($urandom));
        send_req(vrc4m_pkg::REQ_CPU_READ, 16'($urandom), 8'($urandom));
      end else if (r < 82) begin
        n = $urandom_range(3, 8);
        repeat (n) send_req(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom));
      end else begin
        n = $urandom_range(2, 5);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            send_req(vrc4m_pkg::REQ_CPU_WRITE, {1'b0, 15'($urandom)}, 8'($urandom));
          end else begin
            blk = 4'($urandom_range(vrc4m_pkg::BLK_PRG0, vrc4m_pkg::BLK_IRQ));
            send_write(blk, 2'($urandom), 8'($urandom));
          end
        end
      end
    end
  endtask

  initial begin : result_sink
    vrc4m_pkg::res_t got;
    int   hold_left;
    int   taken;
    bit   long_done;
    bit   eager;
    hold_left = 0;
    taken     = 0;
    long_done = 1'b0;
    eager     = 1'b0;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_bus.valid && res_bus.ready) begin
        got.hit         = res_bus.hit;
        got.xlat_addr   = res_bus.xlat_addr;
        got.irq_active  = res_bus.irq_active;
        got.mirror_mode = res_bus.mirror_mode;
        sb.check_result(got);
        taken++;
      end
      if ($urandom_range(0, 99) == 0) eager = !eager;
      if (rst) begin
        res_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (!long_done && taken >= 150) begin
        long_done = 1'b1;
        hold_left = 400;
        res_bus.ready <= 1'b0;
      end else if (eager || $urandom_range(0, 99) < 70) begin
        res_bus.ready <= 1'b1;
      end else begin
        hold_left = pick_gap();
        res_bus.ready <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    sb         = new();
    send_eager = 1'b0;
    sent_count = 0;
    rst                = 1'b1;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = vrc4m_pkg::CFG_PRG_BANKS;
    cfg_bus.data       = 8'd0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = vrc4m_pkg::REQ_CPU_READ;
    req_bus.bus_addr   = 16'd0;
    req_bus.write_data = 8'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    apply_config(vrc4m_pkg::PRG_BANKS_RESET, 1'b0, 1'b0);
    run_directed();
    run_long_timer();
    wait_idle();
    apply_config(8'd1, 1'b1, 1'b1);
    run_random(75);
    wait_idle();
    apply_config(8'd128, 1'b0, 1'b1);
    run_random(75);
    wait_idle();
    apply_config(8'd128, 1'b1, 1'b0);
    run_random(75);
    wait_idle();
    apply_config(8'(1 << $urandom_range(0, 7)), 1'($urandom), 1'($urandom));
    run_random(75);
    wait_idle();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
